// ----- rtl/dsf_pkg.sv -----
`default_nettype none

package dsf_pkg;

  localparam int NUM_SPRINGS = 256;
  localparam int FRAC_BITS   = 16;
  localparam int IDX_W       = 8;
  localparam int DATA_W      = 32;
  localparam int RATIO_W     = 16;
  localparam int CFG_IDX_W   = 2;

  // Product of the shared multiplier, scaled magnitudes and the signed force.
  localparam int PROD_W  = 2 * DATA_W;
  localparam int SCALE_W = PROD_W - FRAC_BITS;
  localparam int FORCE_W = SCALE_W + 2;
  localparam int FHI_W   = FORCE_W - DATA_W;
  localparam int UNIT_W  = FRAC_BITS + 1;

  localparam logic [CFG_IDX_W-1:0] CFG_STIFFNESS   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DAMPING     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BREAK_RATIO = 2'd2;

  localparam logic OP_INIT  = 1'b0;
  localparam logic OP_APPLY = 1'b1;

  localparam logic [RATIO_W-1:0] BREAK_RATIO_RESET = 16'd1536;

  // Magnitude of a two's complement word; the most negative value maps to 2^31.
  function automatic logic [DATA_W-1:0] mag_of(input logic [DATA_W-1:0] v);
    logic [DATA_W-1:0] r;
    r = v[DATA_W-1] ? (~v + 1'b1) : v;
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/dsf_isqrt.sv -----
`default_nettype none

module dsf_isqrt
  import dsf_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                start,
  input  wire logic [PROD_W-1:0]   radicand,
  output logic                     done,
  output logic [DATA_W-1:0]        root
);

  logic              active;
  logic [PROD_W-1:0] rem;
  logic [PROD_W-1:0] res;
  logic [PROD_W-1:0] bitv;
  logic [PROD_W-1:0] trial;

  assign trial = res + bitv;
  assign root  = res[DATA_W-1:0];

  // One result bit per cycle, bit pairs from the top down.
  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      done   <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        active <= 1'b1;
        rem    <= radicand;
        res    <= '0;
        bitv   <= {2'b01, {(PROD_W-2){1'b0}}};
      end else if (active) begin
        if (rem >= trial) begin
          rem <= rem - trial;
          res <= (res >> 1) + bitv;
        end else begin
          res <= res >> 1;
        end
        bitv <= bitv >> 2;
        if (bitv[0]) begin
          active <= 1'b0;
          done   <= 1'b1;
        end
      end
    end
  end

endmodule

`default_nettype wire

// ----- rtl/dsf_div.sv -----
`default_nettype none

module dsf_div
  import dsf_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                start,
  input  wire logic [DATA_W-1:0]   mag,
  input  wire logic [DATA_W-1:0]   divisor,
  output logic                     done,
  output logic [UNIT_W-1:0]        quotient
);

  localparam int CNT_W = $clog2(UNIT_W + 1);

  logic              active;
  logic [CNT_W-1:0]  cnt;
  logic [DATA_W-1:0] rem;
  logic [UNIT_W-1:0] sh;
  logic [DATA_W-1:0] dvs;
  logic [DATA_W:0]   t;

  assign t = {rem, sh[UNIT_W-1]};

  // Restoring division of mag * 2^FRAC_BITS by divisor; mag never exceeds
  // divisor, so the quotient fits in FRAC_BITS + 1 bits.
  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      done   <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        active   <= 1'b1;
        cnt      <= CNT_W'(UNIT_W);
        rem      <= mag >> 1;
        sh       <= {mag[0], {FRAC_BITS{1'b0}}};
        dvs      <= divisor;
        quotient <= '0;
      end else if (active) begin
        if (t >= {1'b0, dvs}) begin
          rem      <= DATA_W'(t - {1'b0, dvs});
          quotient <= {quotient[UNIT_W-2:0], 1'b1};
        end else begin
          rem      <= t[DATA_W-1:0];
          quotient <= {quotient[UNIT_W-2:0], 1'b0};
        end
        sh  <= sh << 1;
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          active <= 1'b0;
          done   <= 1'b1;
        end
      end
    end
  end

endmodule

`default_nettype wire

// ----- rtl/damped_spring_force_engine_unit.sv -----
// Damped spring force engine.
// Items arrive on the in_* channel (valid/ready). Each beat carries an op, a
// spring index and the relative position and velocity of the two particles.
// An initialize beat stores the length of the relative position as the
// spring's rest length and clears its broken mark; its result is all zero.
// An apply beat returns, on the out_* channel, the impulse for the first
// particle, unit(rel) * (-k*(len-rest) - b*|relvel|), saturated to 32 bits,
// along with force_applied and broke_now. A broken spring returns zeros.
// Gains and the break ratio are written through the cfg_* channel, which is
// always ready; write them only while the block is idle.
// One item is in work at a time. An initialize beat runs one 32-step
// square root. An apply beat runs two 32-step square roots, three
// 17-step divisions and a handful of passes through the single shared
// 32x32 multiplier.
// A finished result sits in the output register until out_ready takes it;
// a new item is accepted meanwhile, and its result waits if the register
// is still full. Reset clears all broken marks, out_valid and the gains and
// restores the break ratio; rest lengths are undefined until initialized.
`default_nettype none

module damped_spring_force_engine_unit
  import dsf_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     cfg_valid,
  output logic                          cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [DATA_W-1:0]        cfg_data,
  input  wire logic                     in_valid,
  output logic                          in_ready,
  input  wire logic                     op,
  input  wire logic [IDX_W-1:0]         spring_index,
  input  wire logic signed [DATA_W-1:0] rel_x,
  input  wire logic signed [DATA_W-1:0] rel_y,
  input  wire logic signed [DATA_W-1:0] rel_z,
  input  wire logic signed [DATA_W-1:0] relvel_x,
  input  wire logic signed [DATA_W-1:0] relvel_y,
  input  wire logic signed [DATA_W-1:0] relvel_z,
  output logic                          out_valid,
  input  wire logic                     out_ready,
  output logic signed [DATA_W-1:0]      impulse_x,
  output logic signed [DATA_W-1:0]      impulse_y,
  output logic signed [DATA_W-1:0]      impulse_z,
  output logic                          force_applied,
  output logic                          broke_now
);

  typedef enum logic [3:0] {
    S_IDLE, S_SQ, S_ROOT_GO, S_ROOT_WAIT, S_CHECK, S_BRK, S_BRK_CMP,
    S_KD, S_BV, S_FORCE, S_DIV_GO, S_DIV_WAIT, S_IMP_LO, S_IMP_HI,
    S_IMP_SUM, S_DONE
  } state_t;

  state_t state;

  // Configuration registers.
  logic [DATA_W-1:0]  stiffness;
  logic [DATA_W-1:0]  damping;
  logic [RATIO_W-1:0] break_ratio;

  // Spring table: rest lengths in a memory, broken marks in flip-flops.
  logic [DATA_W-1:0]      rest_mem [NUM_SPRINGS];
  logic [NUM_SPRINGS-1:0] broken;
  logic [DATA_W-1:0]      rest;
  logic                   mem_we;

  // Latched item.
  logic              op_q;
  logic [IDX_W-1:0]  idx_q;
  logic              idx_ok;
  logic [DATA_W-1:0] rx, ry, rz, vx, vy, vz;

  // Working registers.
  logic                vsel;
  logic [1:0]          cnt;
  logic [1:0]          comp;
  logic [PROD_W-1:0]   acc;
  logic [PROD_W-1:0]   mul_p;
  logic [PROD_W-1:0]   pl;
  logic [DATA_W-1:0]   len;
  logic [DATA_W-1:0]   vlen;
  logic [SCALE_W-1:0]  kd;
  logic                negd;
  logic                negf;
  logic [FORCE_W-1:0]  magf;
  logic [UNIT_W-1:0]   unit;
  logic [DATA_W-1:0]   imp [3];
  logic                fa;
  logic                bn;

  // Shared multiplier operands.
  logic [DATA_W-1:0] mul_a;
  logic [DATA_W-1:0] mul_b;
  logic [DATA_W-1:0] sq_src;
  logic [DATA_W-1:0] rel_c;

  // Iterative units.
  logic              root_start;
  logic              root_done;
  logic [DATA_W-1:0] root;
  logic              div_start;
  logic              div_done;
  logic [UNIT_W-1:0] quotient;

  // Force and impulse arithmetic.
  logic [DATA_W-1:0]         dmag;
  logic signed [FORCE_W-1:0] fval;
  logic [PROD_W+DATA_W:0]    psum;
  logic [PROD_W+DATA_W:0]    mval;
  logic                      neg_i;
  logic [DATA_W-1:0]         limit;
  logic [DATA_W-1:0]         msat;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      stiffness   <= '0;
      damping     <= '0;
      break_ratio <= BREAK_RATIO_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_STIFFNESS:   stiffness   <= cfg_data;
        CFG_DAMPING:     damping     <= cfg_data;
        CFG_BREAK_RATIO: break_ratio <= cfg_data[RATIO_W-1:0];
        default:         ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      rest_mem[idx_q] <= len;
    end
    if (in_valid && in_ready) begin
      rest <= rest_mem[spring_index];
    end
  end

  always_comb begin
    case (cnt)
      2'd0:    sq_src = vsel ? vx : rx;
      2'd1:    sq_src = vsel ? vy : ry;
      default: sq_src = vsel ? vz : rz;
    endcase
    case (comp)
      2'd0:    rel_c = rx;
      2'd1:    rel_c = ry;
      default: rel_c = rz;
    endcase
  end

  assign dmag = negd ? (rest - len) : (len - rest);

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state)
      S_SQ: begin
        mul_a = mag_of(sq_src);
        mul_b = mag_of(sq_src);
      end
      S_BRK: begin
        mul_a = DATA_W'(break_ratio);
        mul_b = rest;
      end
      S_KD: begin
        mul_a = stiffness;
        mul_b = dmag;
      end
      S_BV: begin
        mul_a = damping;
        mul_b = vlen;
      end
      S_IMP_LO: begin
        mul_a = DATA_W'(unit);
        mul_b = magf[DATA_W-1:0];
      end
      S_IMP_HI: begin
        mul_a = DATA_W'(unit);
        mul_b = DATA_W'(magf[FORCE_W-1:DATA_W]);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    mul_p <= mul_a * mul_b;
  end

  assign root_start = (state == S_ROOT_GO);
  assign div_start  = (state == S_DIV_GO);
  assign mem_we     = (state == S_CHECK) && idx_ok && (op_q == OP_INIT);

  dsf_isqrt u_isqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (root_start),
    .radicand (acc),
    .done     (root_done),
    .root     (root)
  );

  dsf_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .mag      (mag_of(rel_c)),
    .divisor  (len),
    .done     (div_done),
    .quotient (quotient)
  );

  // Signed force from the two scaled products; kd sits in its register and
  // the damping product is in the multiplier output.
  always_comb begin
    fval = negd ? FORCE_W'(kd) : -FORCE_W'(kd);
    fval = fval - FORCE_W'(mul_p[PROD_W-1:FRAC_BITS]);
  end

  // Impulse magnitude: low and high partial products, scaled and saturated.
  always_comb begin
    psum  = {{(DATA_W+1){1'b0}}, pl} + {1'b0, mul_p, {DATA_W{1'b0}}};
    mval  = psum >> FRAC_BITS;
    neg_i = rel_c[DATA_W-1] != negf;
    limit = neg_i ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
    msat  = (mval > {{(PROD_W+1){1'b0}}, limit}) ? limit : mval[DATA_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      broken    <= '0;
    end else begin
      // In S_DONE the output register is refilled below instead.
      if (out_valid && out_ready && (state != S_DONE)) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            op_q   <= op;
            idx_q  <= spring_index;
            idx_ok <= ({1'b0, spring_index} < (IDX_W + 1)'(NUM_SPRINGS));
            rx     <= rel_x;
            ry     <= rel_y;
            rz     <= rel_z;
            vx     <= relvel_x;
            vy     <= relvel_y;
            vz     <= relvel_z;
            imp[0] <= '0;
            imp[1] <= '0;
            imp[2] <= '0;
            fa     <= 1'b0;
            bn     <= 1'b0;
            vsel   <= 1'b0;
            cnt    <= '0;
            state  <= S_SQ;
          end
        end
        S_SQ: begin
          acc <= (cnt == 2'd0) ? '0 : acc + mul_p;
          cnt <= cnt + 1'b1;
          if (cnt == 2'd3) begin
            state <= S_ROOT_GO;
          end
        end
        S_ROOT_GO: begin
          state <= S_ROOT_WAIT;
        end
        S_ROOT_WAIT: begin
          if (root_done) begin
            if (!vsel) begin
              len   <= root;
              state <= S_CHECK;
            end else begin
              vlen  <= root;
              state <= S_KD;
            end
          end
        end
        S_CHECK: begin
          negd <= len < rest;
          if (!idx_ok) begin
            state <= S_DONE;
          end else if (op_q == OP_INIT) begin
            broken[idx_q] <= 1'b0;
            state         <= S_DONE;
          end else if (broken[idx_q]) begin
            state <= S_DONE;
          end else begin
            state <= S_BRK;
          end
        end
        S_BRK: begin
          state <= S_BRK_CMP;
        end
        S_BRK_CMP: begin
          // Break when stretched to at least ratio times rest (ratio is Q8.8).
          if ((len != '0) && ({{(PROD_W-DATA_W-8){1'b0}}, len, 8'd0} >= mul_p)) begin
            broken[idx_q] <= 1'b1;
            bn            <= 1'b1;
          end
          fa    <= 1'b1;
          vsel  <= 1'b1;
          cnt   <= '0;
          state <= S_SQ;
        end
        S_KD: begin
          state <= S_BV;
        end
        S_BV: begin
          kd    <= mul_p[PROD_W-1:FRAC_BITS];
          state <= S_FORCE;
        end
        S_FORCE: begin
          negf  <= fval[FORCE_W-1];
          magf  <= fval[FORCE_W-1] ? FORCE_W'(-fval) : FORCE_W'(fval);
          comp  <= '0;
          state <= (len == '0) ? S_DONE : S_DIV_GO;
        end
        S_DIV_GO: begin
          state <= S_DIV_WAIT;
        end
        S_DIV_WAIT: begin
          if (div_done) begin
            unit  <= quotient;
            state <= S_IMP_LO;
          end
        end
        S_IMP_LO: begin
          state <= S_IMP_HI;
        end
        S_IMP_HI: begin
          pl    <= mul_p;
          state <= S_IMP_SUM;
        end
        S_IMP_SUM: begin
          imp[comp] <= neg_i ? (~msat + 1'b1) : msat;
          if (comp == 2'd2) begin
            state <= S_DONE;
          end else begin
            comp  <= comp + 1'b1;
            state <= S_DIV_GO;
          end
        end
        S_DONE: begin
          if (!out_valid || out_ready) begin
            impulse_x     <= imp[0];
            impulse_y     <= imp[1];
            impulse_z     <= imp[2];
            force_applied <= fa;
            broke_now     <= bn;
            out_valid     <= 1'b1;
            state         <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- verif/damped_spring_force_engine_unit_test.sv -----
`timescale 1ns / 100ps
`default_nettype none

module damped_spring_force_engine_unit_test;
  import dsf_pkg::*;

  // One result of the block, as the force predictor sees it.
  typedef struct packed {
    logic [DATA_W-1:0] ix;
    logic [DATA_W-1:0] iy;
    logic [DATA_W-1:0] iz;
    logic              applied;
    logic              broke;
  } impulse_t;

  // Small scoreboard. It keeps its own copy of the spring table and the gains,
  // predicts the impulse of every accepted beat and compares results in order.
  class spring_scoreboard;
    logic [DATA_W-1:0]  gain_k;
    logic [DATA_W-1:0]  gain_b;
    logic [RATIO_W-1:0] ratio;
    logic [DATA_W-1:0]  rest_tab [NUM_SPRINGS];
    bit                 broken_tab [NUM_SPRINGS];
    impulse_t           pending_q [$];
    int                 errors;
    int                 checked;
    int                 breaks;
    int                 applies;

    function void clear();
      gain_k = '0;
      gain_b = '0;
      ratio = BREAK_RATIO_RESET;
      foreach (broken_tab[i]) begin
        broken_tab[i] = 0;
        rest_tab[i] = '0;
      end
      errors = 0;
      checked = 0;
      breaks = 0;
      applies = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [DATA_W-1:0] data);
      case (idx)
        CFG_STIFFNESS:   gain_k = data;
        CFG_DAMPING:     gain_b = data;
        CFG_BREAK_RATIO: ratio = data[RATIO_W-1:0];
        default: ;
      endcase
    endfunction

    // Floor of the square root of a 64-bit value, one result bit per step.
    function logic [63:0] root64(logic [63:0] n);
      logic [63:0] res;
      logic [63:0] b;
      res = 0;
      b = 64'd1 << 62;
      while (b > n) b = b >> 2;
      while (b != 0) begin
        if (n >= res + b) begin
          n = n - (res + b);
          res = (res >> 1) + b;
        end else begin
          res = res >> 1;
        end
        b = b >> 2;
      end
      return res;
    endfunction

    function logic [63:0] magnitude(logic [DATA_W-1:0] v);
      return v[DATA_W-1] ? (64'h1_0000_0000 - {32'd0, v}) : {32'd0, v};
    endfunction

    function logic [63:0] length3(logic [DATA_W-1:0] a, logic [DATA_W-1:0] b,
                                  logic [DATA_W-1:0] c);
      logic [63:0] ma, mb, mc;
      ma = magnitude(a);
      mb = magnitude(b);
      mc = magnitude(c);
      return root64(ma * ma + mb * mb + mc * mc);
    endfunction

    function void note_beat(logic o, logic [IDX_W-1:0] idx, logic [DATA_W-1:0] rx,
                            logic [DATA_W-1:0] ry, logic [DATA_W-1:0] rz,
                            logic [DATA_W-1:0] vx, logic [DATA_W-1:0] vy,
                            logic [DATA_W-1:0] vz);
      impulse_t       e;
      logic [63:0]    len, vlen, rest, kd, bv, mag_f, unit, lim, r;
      logic [127:0]   prod;
      logic [DATA_W-1:0] comp [3];
      logic signed [65:0] f;
      bit             negd, neg_f, neg;
      e = '0;
      len = length3(rx, ry, rz);
      if (o == OP_INIT) begin
        rest_tab[idx] = len[DATA_W-1:0];
        broken_tab[idx] = 0;
      end else if (!broken_tab[idx]) begin
        applies++;
        rest = {32'd0, rest_tab[idx]};
        // A spring that has stretched far enough breaks, yet this beat still
        // delivers its impulse.
        if (len > 0 && (len << 8) >= {48'd0, ratio} * rest) begin
          broken_tab[idx] = 1;
          e.broke = 1;
          breaks++;
        end
        e.applied = 1;
        vlen = length3(vx, vy, vz);
        negd = len < rest;
        kd = ({32'd0, gain_k} * (negd ? rest - len : len - rest)) >> FRAC_BITS;
        bv = ({32'd0, gain_b} * vlen) >> FRAC_BITS;
        f = (negd ? $signed({2'b0, kd}) : -$signed({2'b0, kd})) - $signed({2'b0, bv});
        neg_f = f < 0;
        mag_f = neg_f ? 64'(-f) : 64'(f);
        comp[0] = rx;
        comp[1] = ry;
        comp[2] = rz;
        // A zero-length spring has no direction, so its impulse stays zero.
        if (len != 0) begin
          for (int i = 0; i < 3; i++) begin
            unit = (magnitude(comp[i]) << FRAC_BITS) / len;
            neg = comp[i][DATA_W-1] != neg_f;
            lim = neg ? 64'h8000_0000 : 64'h7FFF_FFFF;
            prod = {64'd0, unit} * {64'd0, mag_f};
            r = (prod[127:FRAC_BITS] > {48'd0, lim}) ? lim : prod[FRAC_BITS+63:FRAC_BITS];
            r = neg ? -r : r;
            if (i == 0) e.ix = r[31:0];
            else if (i == 1) e.iy = r[31:0];
            else e.iz = r[31:0];
          end
        end
      end
      pending_q.push_back(e);
    endfunction

    function void check_result(impulse_t got);
      impulse_t e;
      checked++;
      if (pending_q.size() == 0) begin
        $display("%0t: unexpected result %h", $time, got);
        errors++;
        return;
      end
      e = pending_q.pop_front();
      if (got.ix !== e.ix) begin
        $display("%0t: impulse_x expected %h actual %h", $time, e.ix, got.ix);
        errors++;
      end
      if (got.iy !== e.iy) begin
        $display("%0t: impulse_y expected %h actual %h", $time, e.iy, got.iy);
        errors++;
      end
      if (got.iz !== e.iz) begin
        $display("%0t: impulse_z expected %h actual %h", $time, e.iz, got.iz);
        errors++;
      end
      if (got.applied !== e.applied) begin
        $display("%0t: force_applied expected %b actual %b", $time, e.applied, got.applied);
        errors++;
      end
      if (got.broke !== e.broke) begin
        $display("%0t: broke_now expected %b actual %b", $time, e.broke, got.broke);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  logic cfg_valid;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [DATA_W-1:0] cfg_data;
  logic in_valid;
  logic in_ready;
  logic op;
  logic [IDX_W-1:0] spring_index;
  logic signed [DATA_W-1:0] rel_x, rel_y, rel_z, relvel_x, relvel_y, relvel_z;
  logic out_valid;
  logic out_ready;
  logic signed [DATA_W-1:0] impulse_x, impulse_y, impulse_z;
  logic force_applied;
  logic broke_now;

  damped_spring_force_engine_unit dut (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .op(op), .spring_index(spring_index),
    .rel_x(rel_x), .rel_y(rel_y), .rel_z(rel_z),
    .relvel_x(relvel_x), .relvel_y(relvel_y), .relvel_z(relvel_z),
    .out_valid(out_valid), .out_ready(out_ready),
    .impulse_x(impulse_x), .impulse_y(impulse_y), .impulse_z(impulse_z),
    .force_applied(force_applied), .broke_now(broke_now)
  );

  spring_scoreboard sb;

  // Springs that have been initialized; applies go only to these.
  bit  spring_ready [NUM_SPRINGS];
  int  cycle_count;
  bit  stim_done;
  bit  quiet_tail;     // no idling on either side near the end
  bit  hold_receiver;  // long receiver hold-off requested by the sender
  int  hold_cycles;

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  // Watchdog. Besides its own work, each beat may wait out a sender gap and
  // a receiver stall, so the limit is set far above what a beat needs.
  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk);
      cycle_count++;
      if (cycle_count > 1500000) begin
        $display("damped_spring_force_engine_unit_test: FAIL");
        $finish;
      end
    end
  end

  // Result side: sample at the rising edge, change out_ready at the falling
  // edge. Bursts of stall come at random, plus one long hold-off on request.
  initial begin
    impulse_t got;
    int stall;
    bit hold_taken;
    hold_taken = 0;
    out_ready = 0;
    @(negedge clk);
    while (rst) @(negedge clk);
    out_ready = 1;
    forever begin
      @(posedge clk);
      if (out_valid && out_ready) begin
        got.ix = impulse_x;
        got.iy = impulse_y;
        got.iz = impulse_z;
        got.applied = force_applied;
        got.broke = broke_now;
        sb.check_result(got);
      end
      @(negedge clk);
      if (hold_receiver && !hold_taken) begin
        hold_taken = 1;
        out_ready = 0;
        hold_cycles = 0;
        while (hold_cycles < 1200) begin
          @(negedge clk);
          hold_cycles++;
        end
        out_ready = 1;
      end else if (!quiet_tail && $urandom_range(0, 7) == 0) begin
        stall = $urandom_range(1, 10);
        out_ready = 0;
        repeat (stall) @(negedge clk);
        out_ready = 1;
      end
    end
  end

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [DATA_W-1:0] data);
    @(negedge clk);
    cfg_valid = 1;
    cfg_index = idx;
    cfg_data = data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.write_reg(idx, data);
    @(negedge clk);
    cfg_valid = 0;
  endtask

  // Offers one beat, starting at a falling edge, and holds it until accepted.
  // in_valid stays high afterwards; it drops only for a random sender gap or in drain.
  task automatic send_beat(input logic o, input logic [IDX_W-1:0] idx,
                           input logic [DATA_W-1:0] rx, input logic [DATA_W-1:0] ry,
                           input logic [DATA_W-1:0] rz, input logic [DATA_W-1:0] vx,
                           input logic [DATA_W-1:0] vy, input logic [DATA_W-1:0] vz);
    int gap;
    if (!quiet_tail && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 10);
      in_valid = 0;
      repeat (gap) @(negedge clk);
    end
    in_valid = 1;
    op = o;
    spring_index = idx;
    rel_x = rx;
    rel_y = ry;
    rel_z = rz;
    relvel_x = vx;
    relvel_y = vy;
    relvel_z = vz;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_beat(o, idx, rx, ry, rz, vx, vy, vz);
    if (o == OP_INIT) spring_ready[idx] = 1;
    @(negedge clk);
  endtask

  // Lowers valid and waits until every predicted result has come back,
  // then a margin for the block to settle before the next register write.
  task automatic drain();
    in_valid = 0;
    while (sb.pending_q.size() != 0) @(negedge clk);
    repeat (200) @(negedge clk);
  endtask

  // Position component: mostly moderate values, sometimes full range or
  // tiny, so square roots, divisions and saturation all get exercised.
  function automatic logic [DATA_W-1:0] pick_coord();
    case ($urandom_range(0, 9))
      0: return $urandom();
      1: return $urandom_range(0, 3) - 1;
      2: return 32'h8000_0000;
      3: return 32'h7FFF_FFFF;
      default: return $signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000;
    endcase
  endfunction

  task automatic random_phase(input int count);
    logic [IDX_W-1:0] idx;
    logic [DATA_W-1:0] r0, r1, r2;
    int scale;
    for (int n = 0; n < count; n++) begin
      idx = IDX_W'($urandom_range(0, 31));
      if ($urandom_range(0, 15) == 0) idx = IDX_W'($urandom());
      if (!spring_ready[idx] || $urandom_range(0, 4) == 0) begin
        send_beat(OP_INIT, idx, pick_coord(), pick_coord(), pick_coord(),
                  $urandom(), $urandom(), $urandom());
      end else begin
        // Apply with new random coordinates; a quarter of the time they are scaled
        // up eightfold, sometimes far enough to break the spring.
        scale = $urandom_range(0, 3);
        r0 = pick_coord();
        r1 = pick_coord();
        r2 = pick_coord();
        if (scale == 0) begin
          r0 = $signed(r0) <<< 3;
          r1 = $signed(r1) <<< 3;
          r2 = $signed(r2) <<< 3;
        end
        send_beat(OP_APPLY, idx, r0, r1, r2, pick_coord(), pick_coord(), pick_coord());
      end
    end
  endtask

  initial begin
    sb = new();
    sb.clear();
    foreach (spring_ready[i]) spring_ready[i] = 0;
    stim_done = 0;
    quiet_tail = 0;
    hold_receiver = 0;
    rst = 1;
    cfg_valid = 0;
    cfg_index = CFG_STIFFNESS;
    cfg_data = '0;
    in_valid = 0;
    op = OP_INIT;
    spring_index = '0;
    rel_x = '0;
    rel_y = '0;
    rel_z = '0;
    relvel_x = '0;
    relvel_y = '0;
    relvel_z = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 0;

    // Directed part with reset gains: zero gains give zero force.
    send_beat(OP_INIT, 8'd0, 32'h0001_0000, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0);
    send_beat(OP_APPLY, 8'd0, 32'h0002_0000, 32'd0, 32'd0, 32'h7FFF_FFFF, 32'd0, 32'd0);
    drain();

    write_register(CFG_STIFFNESS, 32'h0001_0000);
    write_register(CFG_DAMPING, 32'h0000_8000);
    write_register(CFG_BREAK_RATIO, 32'd1536);
    // Extremes of the position and velocity fields, zero length, breaking,
    // an apply to a broken spring and re-initializing it.
    send_beat(OP_INIT, 8'd255, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
              32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
    send_beat(OP_APPLY, 8'd255, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0001,
              32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    send_beat(OP_INIT, 8'd1, 32'h0001_0000, 32'h0001_0000, 32'd0, 32'd0, 32'd0, 32'd0);
    send_beat(OP_APPLY, 8'd1, 32'd0, 32'd0, 32'd0, 32'h0003_0000, 32'd0, 32'd0);
    send_beat(OP_APPLY, 8'd1, 32'hFFF8_0000, 32'h0008_0000, 32'h0000_0000,
              32'd0, 32'hFFFF_0000, 32'd0);
    send_beat(OP_APPLY, 8'd1, 32'h0000_8000, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0);
    send_beat(OP_INIT, 8'd1, 32'h0001_0000, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0);
    send_beat(OP_APPLY, 8'd1, 32'h0000_4000, 32'hFFFF_C000, 32'd0,
              32'h0000_1000, 32'd0, 32'hFFFF_F000);
    // A spring with zero rest length breaks on the first nonzero length.
    send_beat(OP_INIT, 8'd2, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0);
    send_beat(OP_APPLY, 8'd2, 32'd1, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0);
    send_beat(OP_INIT, 8'd2, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0);
    send_beat(OP_APPLY, 8'd2, 32'd0, 32'd0, 32'd0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'd0);
    drain();

    // Largest gains and the extremes of the break ratio.
    write_register(CFG_STIFFNESS, 32'hFFFF_FFFF);
    write_register(CFG_DAMPING, 32'hFFFF_FFFF);
    write_register(CFG_BREAK_RATIO, 32'd0);
    send_beat(OP_INIT, 8'd3, 32'h0010_0000, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0);
    send_beat(OP_APPLY, 8'd3, 32'h0000_0100, 32'h7FFF_FFFF, 32'h8000_0000,
              32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
    send_beat(OP_INIT, 8'd3, 32'h0010_0000, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0);
    drain();
    write_register(CFG_BREAK_RATIO, 32'h0000_FFFF);
    send_beat(OP_APPLY, 8'd3, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
              32'd0, 32'd0, 32'd0);
    send_beat(OP_APPLY, 8'd3, 32'h0000_0001, 32'hFFFF_FFFF, 32'd0, 32'd1, 32'd0, 32'd0);
    drain();

    // Random phases, each under its own gains.
    for (int ph = 0; ph < 5; ph++) begin
      write_register(CFG_STIFFNESS, ph == 4 ? 32'h0000_0000 : $urandom_range(0, 32'h0004_0000));
      write_register(CFG_DAMPING, ph == 3 ? $urandom() : $urandom_range(0, 32'h0002_0000));
      write_register(CFG_BREAK_RATIO, $urandom_range(256, 4096));
      if (ph == 2) begin
        // Hold the receiver off for a long stretch while beats keep coming,
        // so the output register fills and the input stalls.
        hold_receiver = 1;
      end
      if (ph == 4) quiet_tail = 1;
      random_phase(250);
      drain();
    end
    stim_done = 1;

    $display("Covered %0d results, %0d force evaluations and %0d spring breaks",
             sb.checked, sb.applies, sb.breaks);
    $display("across five gain settings, extreme vectors and a long output hold-off.");
    if (sb.errors == 0 && sb.pending_q.size() == 0) begin
      $display("damped_spring_force_engine_unit_test: PASS");
    end else begin
      $display("damped_spring_force_engine_unit_test: FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire
